>>> rtl/core/dftk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dftk_pkg;

  localparam int LINE_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int OUT_LINE_W      = 16;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_MINUS  = 8'h2D;

  typedef enum logic [2:0] {
    CLS_END    = 3'd0,
    CLS_PUNCT  = 3'd1,
    CLS_INT    = 3'd2,
    CLS_IDENT  = 3'd3,
    CLS_BOOL   = 3'd4,
    CLS_STRING = 3'd5,
    CLS_ERROR  = 3'd6
  } cls_t;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_SLASH   = 6'b000010,
    ST_COMMENT = 6'b000100,
    ST_INT     = 6'b001000,
    ST_IDENT   = 6'b010000,
    ST_STRING  = 6'b100000
  } mode_t;

  typedef struct packed {
    logic       ev;
    cls_t       cls;
    logic [7:0] img;
  } rec_t;

  typedef struct packed {
    logic                  two;
    rec_t                  r0;
    rec_t                  r1;
    logic [OUT_LINE_W-1:0] line;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [2:0] pos;
    logic       t_alive;
    logic       f_alive;
  } match_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return (c != CH_NUL) && !is_space(c) && !is_punct(c);
  endfunction

  function automatic logic [7:0] true_ch(input logic [2:0] p);
    logic [7:0] r;
    case (p)
      3'd0:    r = "t";
      3'd1:    r = "r";
      3'd2:    r = "u";
      3'd3:    r = "e";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] false_ch(input logic [2:0] p);
    logic [7:0] r;
    case (p)
      3'd0:    r = "f";
      3'd1:    r = "a";
      3'd2:    r = "l";
      3'd3:    r = "s";
      3'd4:    r = "e";
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic match_t word_match(input match_t m, input logic [7:0] c);
    match_t     r;
    logic [7:0] lc;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    r.t_alive = m.t_alive && (m.pos < 3'd4) && (lc == true_ch(m.pos));
    r.f_alive = m.f_alive && (m.pos < 3'd5) && (lc == false_ch(m.pos));
    r.pos     = (m.pos < 3'd7) ? m.pos + 3'd1 : m.pos;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/dftk_front.sv
`timescale 1ns / 1ps
`default_nettype none
module dftk_front import dftk_pkg::*; #(
  parameter int LINE_BITS = LINE_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire q_stat_t    q_stat,
  output logic            push,
  output entry_t          push_entry
);

  mode_t                mode_r, mode_nxt;
  logic                 quote_r, quote_nxt;
  logic                 esc_r, esc_nxt;
  match_t               match_r, match_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt, line_inc, line_emit;
  logic [LINE_BITS+OUT_LINE_W-1:0] line_ext;

  logic       acc, cnt, do_start, p_emit;
  rec_t       p_rec;
  logic       s_emit, s_cnt;
  rec_t       s_rec;
  mode_t      s_mode;
  logic [7:0] c, q;
  match_t     m_cur, m_init, m_zero;

  assign c         = in_tdata;
  assign in_tready = !q_stat.full;
  assign acc       = in_tvalid && in_tready;
  assign q         = quote_r ? CH_DQUOTE : CH_SQUOTE;
  assign line_inc  = (line_r == {LINE_BITS{1'b1}}) ? line_r : line_r + 1'b1;

  assign m_zero = '{pos: 3'd0, t_alive: 1'b1, f_alive: 1'b1};
  assign m_cur  = word_match(match_r, c);
  assign m_init = word_match(m_zero, c);

  // classify a byte met between tokens
  always_comb begin
    s_emit = 1'b0;
    s_cnt  = 1'b0;
    s_mode = ST_IDLE;
    s_rec  = '{ev: 1'b1, cls: CLS_ERROR, img: c};
    if (is_space(c)) begin
      s_cnt = (c == CH_LF);
    end else if (c == CH_NUL) begin
      s_emit = 1'b1;
      s_rec  = '{ev: 1'b1, cls: CLS_END, img: 8'd0};
    end else if (c == CH_SLASH) begin
      s_mode = ST_SLASH;
    end else if (c == "=" || c == "(" || c == ")" || c == "{" || c == "}" ||
                 c == ";" || c == "," || c == "+") begin
      s_emit = 1'b1;
      s_rec  = '{ev: 1'b1, cls: CLS_PUNCT, img: c};
    end else if (c == CH_MINUS || (c >= "0" && c <= "9")) begin
      s_mode = ST_INT;
      s_emit = 1'b1;
      s_rec  = '{ev: 1'b0, cls: CLS_INT, img: c};
    end else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == CH_USCORE) begin
      s_mode = ST_IDENT;
      s_emit = 1'b1;
      s_rec  = '{ev: 1'b0, cls: CLS_IDENT, img: c};
    end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
      s_mode = ST_STRING;
    end else begin
      s_emit = 1'b1;
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    quote_nxt = quote_r;
    esc_nxt   = esc_r;
    match_nxt = match_r;
    cnt       = 1'b0;
    do_start  = 1'b0;
    p_emit    = 1'b0;
    p_rec     = '{ev: 1'b1, cls: CLS_END, img: 8'd0};
    case (mode_r)
      ST_IDLE: begin
        do_start = 1'b1;
      end
      ST_SLASH: begin
        if (c == CH_SLASH) begin
          mode_nxt = ST_COMMENT;
        end else begin
          p_emit   = 1'b1;
          p_rec    = '{ev: 1'b1, cls: CLS_PUNCT, img: CH_SLASH};
          do_start = 1'b1;
        end
      end
      ST_COMMENT: begin
        if (c == CH_LF) begin
          cnt      = 1'b1;
          mode_nxt = ST_IDLE;
        end else if (c == CH_NUL) begin
          do_start = 1'b1;
        end
      end
      ST_INT: begin
        if (is_word(c)) begin
          p_emit = 1'b1;
          p_rec  = '{ev: 1'b0, cls: CLS_INT, img: c};
        end else begin
          p_emit   = 1'b1;
          p_rec    = '{ev: 1'b1, cls: CLS_INT, img: 8'd0};
          do_start = 1'b1;
        end
      end
      ST_IDENT: begin
        p_emit = 1'b1;
        if (is_word(c) || c == CH_USCORE) begin
          match_nxt = m_cur;
          p_rec     = '{ev: 1'b0, cls: CLS_IDENT, img: c};
        end else begin
          p_rec = '{ev: 1'b1, cls: CLS_IDENT, img: 8'd0};
          if ((match_r.t_alive && match_r.pos == 3'd4) ||
              (match_r.f_alive && match_r.pos == 3'd5)) begin
            p_rec.cls = CLS_BOOL;
          end
          do_start = 1'b1;
        end
      end
      ST_STRING: begin
        if (c == CH_NUL) begin
          esc_nxt  = 1'b0;
          p_emit   = 1'b1;
          p_rec    = '{ev: 1'b1, cls: CLS_ERROR, img: q};
          do_start = 1'b1;
        end else if (esc_r) begin
          esc_nxt = 1'b0;
          cnt     = (c == CH_LF);
          p_emit  = (c != CH_BSLASH);
          p_rec   = '{ev: 1'b0, cls: CLS_STRING, img: c};
        end else if (c == CH_BSLASH) begin
          esc_nxt = 1'b1;
        end else if (c == q) begin
          p_emit   = 1'b1;
          p_rec    = '{ev: 1'b1, cls: CLS_STRING, img: 8'd0};
          mode_nxt = ST_IDLE;
        end else begin
          cnt    = (c == CH_LF);
          p_emit = 1'b1;
          p_rec  = '{ev: 1'b0, cls: CLS_STRING, img: c};
        end
      end
      default: begin
        mode_nxt = ST_IDLE;
      end
    endcase
    if (do_start) begin
      mode_nxt = s_mode;
      cnt      = cnt | s_cnt;
      if (s_mode == ST_IDENT) begin
        match_nxt = m_init;
      end
      if (s_mode == ST_STRING) begin
        quote_nxt = (c == CH_DQUOTE);
        esc_nxt   = 1'b0;
      end
    end
    line_nxt = cnt ? line_inc : line_r;
  end

  // only a string byte counts its newline before emitting
  assign line_emit = (mode_r == ST_STRING && c == CH_LF) ? line_inc : line_r;
  assign line_ext  = {{OUT_LINE_W{1'b0}}, line_emit};

  always_comb begin
    push_entry.two  = p_emit && do_start && s_emit;
    push_entry.r0   = p_emit ? p_rec : s_rec;
    push_entry.r1   = s_rec;
    push_entry.line = line_ext[OUT_LINE_W-1:0];
    push            = acc && (p_emit || (do_start && s_emit));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ST_IDLE;
      quote_r <= 1'b0;
      esc_r   <= 1'b0;
      match_r <= '{pos: 3'd0, t_alive: 1'b1, f_alive: 1'b1};
      line_r  <= {{(LINE_BITS-1){1'b0}}, 1'b1};
    end else if (acc) begin
      mode_r  <= mode_nxt;
      quote_r <= quote_nxt;
      esc_r   <= esc_nxt;
      match_r <= match_nxt;
      line_r  <= line_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/dftk_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module dftk_queue import dftk_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t push_entry,
  input  wire logic   pop,
  output entry_t      head,
  output q_stat_t     q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign q_stat.full  = (cnt_r == CW'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/dftk_back.sv
`timescale 1ns / 1ps
`default_nettype none
module dftk_back import dftk_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire entry_t  head,
  input  wire q_stat_t q_stat,
  output logic         pop,
  output logic         out_tvalid,
  input  wire logic    out_tready,
  output logic [23:0]  out_tdata,   // [7:0] image_byte, [23:8] line_number
  output logic [3:0]   out_tuser,   // [0] event_res, [3:1] token_class
  output logic         out_tlast
);

  logic phase_r, phase_nxt;
  logic xfer;
  rec_t rec;

  assign out_tvalid = !q_stat.empty;
  assign xfer       = out_tvalid && out_tready;
  // second record of a pair goes out on the next transaction
  assign rec        = (head.two && !phase_r) ? head.r0 : (head.two ? head.r1 : head.r0);
  assign out_tlast  = !head.two || phase_r;
  assign out_tdata  = {head.line, rec.img};
  assign out_tuser  = {rec.cls, rec.ev};
  assign pop        = xfer && out_tlast;
  assign phase_nxt  = xfer ? (head.two && !phase_r) : phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/data_file_tokenizer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Ports                  Payload
// in_      in   tvalid/tready/tdata    data_byte
// out_     out  tvalid/tready/tdata/   image_byte, line_number; tuser event_res,
//               tuser/tlast            token_class; tlast = last
//
// The scanner takes one byte per cycle while in_tready is high.
// A byte yields zero, one or two records; the output side sends one record per
// cycle while out_tready is high, so bytes that yield two records take two transfers.
// A queue of QUEUE_DEPTH entries sits between scanner and output; in_tready
// drops only while it is full. Synchronous active-low reset, no clearing pass.
module data_file_tokenizer_unit import dftk_pkg::*; #(
  parameter int LINE_BITS   = LINE_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] data_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,   // [7:0] image_byte, [23:8] line_number
  output logic [3:0]       out_tuser,   // [0] event_res, [3:1] token_class
  output logic             out_tlast
);

  q_stat_t q_stat;
  logic    push, pop;
  entry_t  push_entry, head;

  dftk_front #(.LINE_BITS(LINE_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  dftk_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  dftk_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // the first of two records from one byte always closes a token
  a_pair_head_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser[0])
    else $error("leading record of a pair is not an end record");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] && out_tuser[3:1] == CLS_END |-> out_tlast)
    else $error("end-of-text record not last");

  a_stall_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty queue");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && q_stat.full |-> pop)
    else $error("push into full queue");

endmodule
`default_nettype wire
